FILE: rtl/core/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    localparam int FRAME_LEN    = 25;
    localparam int NUM_CHANNELS = 16;
    localparam int DATA_BYTES   = FRAME_LEN - 3;
    localparam int CHAN_W       = 11;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int DATA_W       = DATA_BYTES * 8;

    localparam logic [CNT_W-1:0] FLAGS_POS = CNT_W'(FRAME_LEN - 2);
    localparam logic [CNT_W-1:0] END_POS   = CNT_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);

    localparam logic [7:0] HEADER_BYTE   = 8'h0F;
    localparam logic [7:0] END_BYTE      = 8'h00;
    localparam logic [7:0] TIMEOUT_RESET = 8'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  channel_index;
        logic [CHAN_W-1:0] channel_value;
        logic              frame_ok;
        logic              cause;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic             shift_data;
        logic             load_flags;
        logic             tick_step;
        logic             tick_clear;
        logic             run_start;
        logic             run_use_frame;
        logic             run_ok;
        logic             run_cause;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] out_index;
    } t_dp_cmd;

    typedef struct packed {
        logic header_hit;
        logic end_hit;
        logic flags_zero;
        logic tick_timeout;
        logic out_blocked;
    } t_dp_status;

    function automatic logic [CHAN_W-1:0] default_value(input logic [IDX_W-1:0] idx);
        logic [CHAN_W-1:0] v;
        v = CHAN_W'(282);
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd12, 4'd13, 4'd14, 4'd15: v = CHAN_W'(1002);
            4'd5:    v = CHAN_W'(1722);
            default: v = CHAN_W'(282);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sfr_ctrl.sv
`default_nettype none

module sfr_ctrl
    import sfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_in_item   i_in_data,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_in_stall
);

    t_state           r_state, n_state;
    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [IDX_W-1:0] r_chan, n_chan;

    logic in_xfer;
    logic is_tick;
    logic is_end;
    logic start_tick;
    logic start_frame;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign is_tick     = (i_in_data.cmd == CMD_TICK);
    assign is_end      = r_in_frame && (r_byte_count == END_POS);
    assign start_tick  = in_xfer && is_tick && i_status.tick_timeout;
    assign start_frame = in_xfer && !is_tick && is_end && i_status.end_hit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_tick || start_frame) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.out_blocked && r_chan == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.out_index     = r_chan;
        o_cmd.out_last      = (r_chan == LAST_IDX);
        n_chan              = r_chan;
        unique case (r_state)
            ST_IDLE: begin
                n_chan              = '0;
                o_cmd.tick_step     = in_xfer && is_tick;
                o_cmd.tick_clear    = start_frame;
                o_cmd.shift_data    = in_xfer && !is_tick && r_in_frame
                                      && (r_byte_count < FLAGS_POS);
                o_cmd.load_flags    = in_xfer && !is_tick && r_in_frame
                                      && (r_byte_count == FLAGS_POS);
                o_cmd.run_start     = start_tick || start_frame;
                o_cmd.run_use_frame = start_frame && i_status.flags_zero;
                o_cmd.run_ok        = start_frame && i_status.flags_zero;
                o_cmd.run_cause     = start_tick;
            end
            ST_EMIT: begin
                o_cmd.out_load = !i_status.out_blocked;
                if (!i_status.out_blocked) begin
                    n_chan = r_chan + IDX_W'(1);
                end
            end
            default: n_chan = '0;
        endcase
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        if (in_xfer && !is_tick) begin
            if (!r_in_frame) begin
                if (i_status.header_hit) begin
                    n_in_frame   = 1'b1;
                    n_byte_count = CNT_W'(1);
                end
            end else if (is_end) begin
                n_in_frame   = 1'b0;
                n_byte_count = '0;
            end else begin
                n_byte_count = r_byte_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_chan       <= '0;
        end else begin
            r_state      <= n_state;
            r_in_frame   <= n_in_frame;
            r_byte_count <= n_byte_count;
            r_chan       <= n_chan;
        end
    end

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.run_start |-> (r_state == ST_IDLE) && in_xfer)
        else $error("run started outside idle");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && o_cmd.out_load && o_cmd.out_last |=> r_state == ST_IDLE)
        else $error("run did not end after last channel");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= END_POS)
        else $error("byte count out of range");

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_byte_count == '0)
        else $error("byte count set while hunting");

endmodule

`default_nettype wire

FILE: rtl/core/sfr_datapath.sv
`default_nettype none

module sfr_datapath
    import sfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_data,
    input  wire t_dp_cmd  i_cmd,
    input  wire logic     i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic     i_out_stall,
    output t_dp_status    o_status,
    output logic          o_out_valid,
    output t_out_item     o_out_data
);

    logic [DATA_W-1:0] r_data;
    logic [7:0]        r_flags;
    logic [7:0]        r_tick, n_tick;
    logic [7:0]        r_timeout;
    logic              r_use_frame;
    logic              r_ok;
    logic              r_cause;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    assign n_tick = (r_tick == 8'hFF) ? r_tick : r_tick + 8'd1;

    assign o_status.header_hit   = (i_in_data.rx_byte == HEADER_BYTE);
    assign o_status.end_hit      = (i_in_data.rx_byte == END_BYTE);
    assign o_status.flags_zero   = (r_flags == 8'h00);
    assign o_status.tick_timeout = (n_tick >= r_timeout);
    assign o_status.out_blocked  = r_out_valid && i_out_stall;

    always_comb begin
        n_out.channel_index = i_cmd.out_index;
        n_out.channel_value = r_use_frame ? r_data[CHAN_W-1:0]
                                          : default_value(i_cmd.out_index);
        n_out.frame_ok      = r_ok;
        n_out.cause         = r_cause;
        n_out.last          = i_cmd.out_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_data) begin
            r_data <= {i_in_data.rx_byte, r_data[DATA_W-1:8]};
        end else if (i_cmd.out_load && r_use_frame) begin
            r_data <= {CHAN_W'(0), r_data[DATA_W-1:CHAN_W]};
        end
        if (i_cmd.load_flags) begin
            r_flags <= i_in_data.rx_byte;
        end
        if (i_cmd.run_start) begin
            r_use_frame <= i_cmd.run_use_frame;
            r_ok        <= i_cmd.run_ok;
            r_cause     <= i_cmd.run_cause;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_clear) begin
                r_tick <= '0;
            end else if (i_cmd.tick_step) begin
                r_tick <= n_tick;
            end
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    a_tick_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_clear |=> r_tick == '0)
        else $error("tick counter not cleared");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("loaded result not valid");

endmodule

`default_nettype wire

FILE: rtl/core/sbus_frame_receiver.sv
// a frame end byte or a timeout tick starts a run: emit state, then the output register
// one result per cycle unless output stalls; 16 results per run from a single output register
// input is stalled during a run (longer if the output stalls); else every valid item is taken
// reset: synchronous, active low; hunting for a header, tick count 0, timeout_ticks 2
// frame byte store is not cleared; every byte read was written by the current frame
`default_nettype none

module sbus_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    sfr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
